>>> src/rc_pwm_receiver_decoder_core_assert.svh
// assertion macros for the rc pwm decoder core
`ifndef RC_PWM_RECEIVER_DECODER_CORE_ASSERT_SVH
`define RC_PWM_RECEIVER_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked on clk with reset masked
`define RCPWM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk with reset masked
`define RCPWM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> src/rcpwm_pkg.sv
// shared types and constants for the rc pwm decoder
package rcpwm_pkg;

	localparam int TIME_WIDTH = 32;
	localparam int NUM_CH     = 4;
	localparam int CH_BITS    = $clog2(NUM_CH);

	// channel codes
	localparam logic [1:0] CH_THROTTLE = 2'd0;
	localparam logic [1:0] CH_STEERING = 2'd1;
	localparam logic [1:0] CH_KNOB     = 2'd2;
	localparam logic [1:0] CH_BUTTON   = 2'd3;

	// register indexes
	localparam logic [2:0] REG_PULSE_MIN     = 3'd0;
	localparam logic [2:0] REG_PULSE_MAX     = 3'd1;
	localparam logic [2:0] REG_PRESS_LEVEL   = 3'd2;
	localparam logic [2:0] REG_LIFT_LEVEL    = 3'd3;
	localparam logic [2:0] REG_FORWARD_LEVEL = 3'd4;

	localparam logic [15:0] PULSE_MIN_RST     = 16'd1000;
	localparam logic [15:0] PULSE_MAX_RST     = 16'd2000;
	localparam logic [15:0] PRESS_LEVEL_RST   = 16'd1600;
	localparam logic [15:0] LIFT_LEVEL_RST    = 16'd1400;
	localparam logic [15:0] FORWARD_LEVEL_RST = 16'd1200;

	localparam logic [15:0] WIDTH_RST = 16'd1500;
	localparam logic [15:0] WIDTH_SAT = 16'hFFFF;

	// fixed normalization window
	localparam logic [10:0] NORM_LO  = 11'd1000;
	localparam logic [10:0] NORM_HI  = 11'd2000;
	localparam logic [10:0] NORM_MID = 11'd1500;

	typedef struct packed {
		logic [15:0] pulse_min;
		logic [15:0] pulse_max;
		logic [15:0] press_level;
		logic [15:0] lift_level;
		logic [15:0] forward_level;
	} cfg_t;

	typedef struct packed {
		logic pressed;
		logic lifted;
		logic auto_mode;
		logic forward;
	} flags_t;

	localparam flags_t FLAGS_RST = '{pressed: 1'b0, lifted: 1'b0, auto_mode: 1'b0,
		forward: 1'b1};

endpackage

>>> src/rc_pwm_receiver_decoder_core.sv
// top level of the four-channel rc pwm pulse width decoder
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------------
//  in      | in_valid  | in_stall  | channel, level, time_us
//  out     | out_valid | out_stall | four widths, steering_norm, throttle_level,
//          |           |           | brake_level, auto_mode, forward
//  cfg     | cfg_we    | -         | cfg_index, cfg_data
//
// one edge word per cycle sustained while out_stall is low; each word gives one result
// word once it has passed the input register, then the result register
// the per-channel state is read and written in the single pass from the
// input register to the result register, so back-to-back words always see
// the update of the word before
// a stalled result holds in the result register while one more word waits
// in the input register; in_stall rises only when both are full
// reset clears control, sets flags to their defaults (forward high) and widths to 1500, and loads register defaults
module rc_pwm_receiver_decoder_core
	import rcpwm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	// edge words
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         channel,
	input  logic               level,
	input  logic [31:0]        time_us,
	// result words
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        throttle_width,
	output logic [15:0]        steering_width,
	output logic [15:0]        knob_width,
	output logic [15:0]        button_width,
	output logic signed [9:0]  steering_norm,
	output logic [8:0]         throttle_level,
	output logic [8:0]         brake_level,
	output logic               auto_mode,
	output logic               forward,
	// register writes
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	// handshake
	logic in_acc;
	logic adv_s1;

	// input register
	logic                  valid_s1;
	logic [1:0]            ch_s1;
	logic                  lvl_s1;
	logic [31:0]           time_s1;
	logic [TIME_WIDTH-1:0] tval;

	// channel state
	logic [TIME_WIDTH-1:0] edge_start_q [NUM_CH];
	logic [NUM_CH-1:0]     armed_q;
	logic [15:0]           width_q [NUM_CH];
	flags_t                flags_q;
	cfg_t                  cfg_q;

	// single-pass results
	logic        done;
	logic [15:0] width_new;
	flags_t      flags_next;
	logic [15:0] width_n [NUM_CH];

	// result register
	logic        valid_s2;
	logic [15:0] width_s2 [NUM_CH];
	flags_t      flags_s2;

	// output normalization
	logic [10:0] steer_c;
	logic [10:0] thr_c;
	logic [10:0] steer_d;

	// pass forward when the result register is empty or drains this cycle
	assign adv_s1   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !adv_s1;
	assign in_acc   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc || (valid_s1 && !adv_s1);
		end
	end

	// payload of the input register, no reset needed
	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_s1   <= channel;
			lvl_s1  <= level;
			time_s1 <= time_us;
		end
	end

	// all 32 time bits take part, since TIME_WIDTH matches time_us
	assign tval = TIME_WIDTH'(time_s1);

	// register writes, out-of-range index ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pulse_min     <= PULSE_MIN_RST;
			cfg_q.pulse_max     <= PULSE_MAX_RST;
			cfg_q.press_level   <= PRESS_LEVEL_RST;
			cfg_q.lift_level    <= LIFT_LEVEL_RST;
			cfg_q.forward_level <= FORWARD_LEVEL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PULSE_MIN:     cfg_q.pulse_min     <= cfg_data;
				REG_PULSE_MAX:     cfg_q.pulse_max     <= cfg_data;
				REG_PRESS_LEVEL:   cfg_q.press_level   <= cfg_data;
				REG_LIFT_LEVEL:    cfg_q.lift_level    <= cfg_data;
				REG_FORWARD_LEVEL: cfg_q.forward_level <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rcpwm_pulse_calc u_calc (
		.channel    (ch_s1),
		.level      (lvl_s1),
		.time_val   (tval),
		.start      (edge_start_q[ch_s1]),
		.armed      (armed_q[ch_s1]),
		.cfg        (cfg_q),
		.flags      (flags_q),
		.done       (done),
		.width_new  (width_new),
		.flags_next (flags_next)
	);

	// widths after this word, fed to both the state and the result register
	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			width_n[i] = width_q[i];
		end
		if (done) begin
			width_n[ch_s1] = width_new;
		end
	end

	// start times are only read while armed, so they need no reset
	always_ff @(posedge clk) begin
		if (adv_s1 && lvl_s1) begin
			edge_start_q[ch_s1] <= tval;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q <= '0;
			flags_q <= FLAGS_RST;
			for (int i = 0; i < NUM_CH; i++) begin
				width_q[i] <= WIDTH_RST;
			end
		end else if (adv_s1) begin
			// rising edge arms, falling edge on an armed channel disarms
			if (lvl_s1) begin
				armed_q[ch_s1] <= 1'b1;
			end else if (done) begin
				armed_q[ch_s1] <= 1'b0;
			end
			flags_q <= flags_next;
			for (int i = 0; i < NUM_CH; i++) begin
				width_q[i] <= width_n[i];
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= adv_s1 || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			flags_s2 <= flags_next;
			for (int i = 0; i < NUM_CH; i++) begin
				width_s2[i] <= width_n[i];
			end
		end
	end

	// fixed 1000..2000 window for the normalized views
	always_comb begin
		priority if (width_s2[CH_STEERING] < 16'(NORM_LO)) begin
			steer_c = NORM_LO;
		end else if (width_s2[CH_STEERING] > 16'(NORM_HI)) begin
			steer_c = NORM_HI;
		end else begin
			steer_c = width_s2[CH_STEERING][10:0];
		end
	end

	always_comb begin
		priority if (width_s2[CH_THROTTLE] < 16'(NORM_LO)) begin
			thr_c = NORM_LO;
		end else if (width_s2[CH_THROTTLE] > 16'(NORM_HI)) begin
			thr_c = NORM_HI;
		end else begin
			thr_c = width_s2[CH_THROTTLE][10:0];
		end
	end

	// -500..500 fits the low ten bits in two's complement
	assign steer_d       = steer_c - NORM_MID;
	assign steering_norm = signed'(steer_d[9:0]);

	assign throttle_level = (thr_c > NORM_MID) ? 9'(thr_c - NORM_MID) : 9'd0;
	assign brake_level    = (thr_c < NORM_MID) ? 9'(NORM_MID - thr_c) : 9'd0;

	assign out_valid      = valid_s2;
	assign throttle_width = width_s2[CH_THROTTLE];
	assign steering_width = width_s2[CH_STEERING];
	assign knob_width     = width_s2[CH_KNOB];
	assign button_width   = width_s2[CH_BUTTON];
	assign auto_mode      = flags_s2.auto_mode;
	assign forward        = flags_s2.forward;

	// checks
	`include "rc_pwm_receiver_decoder_core_assert.svh"

	`RCPWM_ASSERT_NOW(a_stall_only_full, in_stall, valid_s1 && valid_s2 && out_stall,
		"input stalled while a stage was free")
	`RCPWM_ASSERT_NEXT(a_rise_arms, adv_s1 && lvl_s1, armed_q[$past(ch_s1)],
		"rising edge did not arm its channel")
	`RCPWM_ASSERT_NOW(a_norm_range, out_valid,
		(steering_norm >= -10'sd500) && (steering_norm <= 10'sd500),
		"steering_norm out of range")
	`RCPWM_ASSERT_NOW(a_thr_brake_excl, out_valid, (throttle_level == 9'd0) || (brake_level == 9'd0),
		"throttle and brake both active")

endmodule

>>> src/rcpwm_pulse_calc.sv
// pulse width measure, clamp (saturate on the button) and button/knob flag update for one edge word
module rcpwm_pulse_calc
	import rcpwm_pkg::*;
(
	input  logic [1:0]            channel,
	input  logic                  level,
	input  logic [TIME_WIDTH-1:0] time_val,
	input  logic [TIME_WIDTH-1:0] start,
	input  logic                  armed,
	input  cfg_t                  cfg,
	input  flags_t                flags,
	output logic                  done,
	output logic [15:0]           width_new,
	output flags_t                flags_next
);

	logic [TIME_WIDTH-1:0] diff;
	logic [15:0]           clamped;
	logic [15:0]           sat;

	// modulo subtract wraps naturally at the time width
	assign diff = time_val - start;
	assign done = !level && armed;

	always_comb begin
		priority if (diff < TIME_WIDTH'(cfg.pulse_min)) begin
			clamped = cfg.pulse_min;
		end else if (diff > TIME_WIDTH'(cfg.pulse_max)) begin
			clamped = cfg.pulse_max;
		end else begin
			clamped = diff[15:0];
		end
	end

	assign sat = (diff > TIME_WIDTH'(WIDTH_SAT)) ? WIDTH_SAT : diff[15:0];

	always_comb begin
		flags_next = flags;
		width_new  = clamped;
		unique case (channel)
			CH_THROTTLE, CH_STEERING: begin
				width_new = clamped;
			end
			CH_KNOB: begin
				width_new = clamped;
				if (done) begin
					flags_next.forward = (clamped >= cfg.forward_level);
				end
			end
			CH_BUTTON: begin
				width_new = sat;
				if (done) begin
					flags_next.pressed = (sat >= cfg.press_level);
					flags_next.lifted  = (sat <= cfg.lift_level);
					// press then lift toggles auto
					if (flags.pressed && (sat <= cfg.lift_level)) begin
						flags_next.auto_mode = !flags.auto_mode;
					end
				end
			end
			default: begin
				width_new = clamped;
			end
		endcase
	end

endmodule

>>> sim/rc_pwm_receiver_decoder_core_tb.sv
// self-checking testbench for the four-channel rc pwm pulse width decoder
`timescale 1ns / 100ps

module rc_pwm_receiver_decoder_core_tb;
	import rcpwm_pkg::*;

	// register indexes past the end of the list, writes there are dropped
	localparam logic [2:0] REG_SPARE_LO = 3'd5;
	localparam logic [2:0] REG_SPARE_HI = 3'd7;

	localparam int QUIET_LIMIT = 2000;  // cycles with no word moving on either side
	localparam int HOLD_CYCLES = 60;    // long receiver hold-off
	localparam int SETTLE      = 4;     // two-stage pipe plus margin

	// one edge word
	typedef struct {
		logic [1:0]  ch;
		logic        lvl;
		logic [31:0] t;
	} edge_word_t;

	// one decoded view, as the result word carries it
	typedef struct {
		logic [15:0]        throttle_width;
		logic [15:0]        steering_width;
		logic [15:0]        knob_width;
		logic [15:0]        button_width;
		logic signed [9:0]  steering_norm;
		logic [8:0]         throttle_level;
		logic [8:0]         brake_level;
		logic               auto_mode;
		logic               forward;
	} view_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         channel = '0;
	logic               level = 1'b0;
	logic [31:0]        time_us = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [15:0]        throttle_width;
	logic [15:0]        steering_width;
	logic [15:0]        knob_width;
	logic [15:0]        button_width;
	logic signed [9:0]  steering_norm;
	logic [8:0]         throttle_level;
	logic [8:0]         brake_level;
	logic               auto_mode;
	logic               forward;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [15:0]        cfg_data = '0;

	rc_pwm_receiver_decoder_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.channel        (channel),
		.level          (level),
		.time_us        (time_us),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.throttle_width (throttle_width),
		.steering_width (steering_width),
		.knob_width     (knob_width),
		.button_width   (button_width),
		.steering_norm  (steering_norm),
		.throttle_level (throttle_level),
		.brake_level    (brake_level),
		.auto_mode      (auto_mode),
		.forward        (forward),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	always #5 clk = ~clk;

	// edge words waiting to be driven, decoded views waiting to come out
	edge_word_t edge_q[$];
	view_t      view_q[$];

	// decoder state as the testbench tracks it
	cfg_t        cfg;
	logic [31:0] start_q[4];
	logic        armed_q[4];
	logic [15:0] width_q[4];
	logic        pressed_q;
	logic        lifted_q;
	logic        auto_q;
	logic        fwd_q;

	// stimulus generator's own idea of which channels have a pulse open
	logic        gen_armed[4];
	logic [31:0] gen_start[4];
	logic [31:0] gen_now;

	int errors = 0;
	int n_in = 0;
	int n_out = 0;
	int n_toggle = 0;
	int n_settings = 1;
	int src_idle_pct = 31;
	int snk_idle_pct = 31;
	int hold_at = -1;
	int hold_left = 0;
	bit hold_done = 1'b0;
	bit in_taken = 1'b0;
	int quiet = 0;

	// apply one edge to the tracked state and return the view it leaves behind
	function automatic view_t decode_edge(logic [1:0] ch, logic lvl, logic [31:0] t);
		logic [31:0] w;
		logic [15:0] c;
		logic        was_pressed;
		logic [15:0] s;
		logic [15:0] th;
		view_t       v;
		if (lvl) begin
			// rising edge: (re)start the pulse, a second rise just moves the start
			start_q[ch] = t;
			armed_q[ch] = 1'b1;
		end else if (armed_q[ch]) begin
			// falling edge on an open pulse, width wraps modulo 2^32
			w = t - start_q[ch];
			armed_q[ch] = 1'b0;
			if (ch != CH_BUTTON) begin
				// min checked first, so min above max gives min for short pulses
				if (w < cfg.pulse_min)
					c = cfg.pulse_min;
				else if (w > cfg.pulse_max)
					c = cfg.pulse_max;
				else
					c = w[15:0];
				width_q[ch] = c;
				if (ch == CH_KNOB)
					fwd_q = (c >= cfg.forward_level);
			end else begin
				c = (w > 32'(WIDTH_SAT)) ? WIDTH_SAT : w[15:0];
				was_pressed = pressed_q;
				width_q[CH_BUTTON] = c;
				// press and lift tested on their own, both may hold at once
				pressed_q = (c >= cfg.press_level);
				lifted_q = (c <= cfg.lift_level);
				if (was_pressed && lifted_q) begin
					auto_q = ~auto_q;
					n_toggle++;
				end
			end
		end
		// falling edge with nothing open leaves the state alone
		s = width_q[CH_STEERING];
		if (s < NORM_LO) s = 16'(NORM_LO);
		if (s > NORM_HI) s = 16'(NORM_HI);
		th = width_q[CH_THROTTLE];
		if (th < NORM_LO) th = 16'(NORM_LO);
		if (th > NORM_HI) th = 16'(NORM_HI);
		v.throttle_width = width_q[CH_THROTTLE];
		v.steering_width = width_q[CH_STEERING];
		v.knob_width     = width_q[CH_KNOB];
		v.button_width   = width_q[CH_BUTTON];
		v.steering_norm  = 10'(s - 16'(NORM_MID));
		v.throttle_level = (th > NORM_MID) ? 9'(th - 16'(NORM_MID)) : 9'd0;
		v.brake_level    = (th < NORM_MID) ? 9'(16'(NORM_MID) - th) : 9'd0;
		v.auto_mode      = auto_q;
		v.forward        = fwd_q;
		return v;
	endfunction

	task automatic push_edge(logic [1:0] ch, logic lvl, logic [31:0] t);
		edge_word_t w;
		w.ch = ch;
		w.lvl = lvl;
		w.t = t;
		edge_q.push_back(w);
	endtask

	// pulse widths weighted toward the interesting spots
	function automatic logic [31:0] pick_width();
		logic [31:0] base;
		case ($urandom_range(9))
			0, 1, 2, 3, 4: return $urandom_range(2100, 900);
			5: begin
				// right around a configured level or the fixed window
				case ($urandom_range(7))
					0: base = cfg.pulse_min;
					1: base = cfg.pulse_max;
					2: base = cfg.press_level;
					3: base = cfg.lift_level;
					4: base = cfg.forward_level;
					5: base = 32'(NORM_LO);
					6: base = 32'(NORM_MID);
					default: base = 32'(NORM_HI);
				endcase
				return base + $urandom_range(4) - 2;
			end
			6: return $urandom_range(65535);
			7: return $urandom();
			8: return 32'(WIDTH_SAT) + $urandom_range(2) - 1;
			default: return $urandom_range(3);
		endcase
	endfunction

	// mostly well-formed rise/fall pairs interleaved across channels, some noise
	task automatic gen_edges(int n);
		logic [1:0] ch;
		for (int i = 0; i < n; i++) begin
			gen_now += $urandom_range(3000, 1);
			ch = 2'($urandom_range(3));
			if ($urandom_range(99) < 15) begin
				push_edge(ch, 1'($urandom_range(1)), $urandom());
			end else if (!gen_armed[ch] || $urandom_range(9) == 0) begin
				gen_armed[ch] = 1'b1;
				gen_start[ch] = gen_now;
				push_edge(ch, 1'b1, gen_now);
			end else begin
				gen_armed[ch] = 1'b0;
				push_edge(ch, 1'b0, gen_start[ch] + pick_width());
			end
		end
	endtask

	// every word gives a result, so empty queues and a low valid mean idle
	task automatic drain();
		do
			@(negedge clk);
		while (edge_q.size() != 0 || in_valid || view_q.size() != 0);
		repeat (SETTLE) @(negedge clk);
	endtask

	// one write per call, enable dropped for a cycle before the next one
	task automatic write_reg(logic [2:0] idx, logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_PULSE_MIN:     cfg.pulse_min = data;
			REG_PULSE_MAX:     cfg.pulse_max = data;
			REG_PRESS_LEVEL:   cfg.press_level = data;
			REG_LIFT_LEVEL:    cfg.lift_level = data;
			REG_FORWARD_LEVEL: cfg.forward_level = data;
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_config(logic [15:0] lo, logic [15:0] hi, logic [15:0] press,
			logic [15:0] lift, logic [15:0] fwd);
		write_reg(REG_PULSE_MIN, lo);
		write_reg(REG_PULSE_MAX, hi);
		write_reg(REG_PRESS_LEVEL, press);
		write_reg(REG_LIFT_LEVEL, lift);
		write_reg(REG_FORWARD_LEVEL, fwd);
		n_settings++;
		@(negedge clk);
	endtask

	// sender: a new word goes out when the line is free or the last one was taken
	always @(negedge clk) begin
		edge_word_t w;
		if (arst_n && (!in_valid || in_taken)) begin
			if (edge_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
				w = edge_q.pop_front();
				in_valid <= 1'b1;
				channel <= w.ch;
				level <= w.lvl;
				time_us <= w.t;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// input side accept: decode the edge the moment the block takes it
	always @(posedge clk) begin
		in_taken = arst_n && in_valid && !in_stall;
		if (in_taken) begin
			view_q.push_back(decode_edge(channel, level, time_us));
			n_in++;
		end
	end

	// receiver stall, with one long hold-off once the sender is far enough along
	always @(negedge clk) begin
		if (!hold_done && hold_at >= 0 && n_in >= hold_at) begin
			hold_left = HOLD_CYCLES;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < snk_idle_pct);
		end
	end

	task automatic mismatch(string field, int want, int got);
		$display("%0t: %s mismatch, expected %0d got %0d", $time, field, want, got);
		errors++;
	endtask

	// result side: each word taken is held against the oldest decoded view
	always @(posedge clk) begin
		view_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_out++;
			if (view_q.size() == 0) begin
				$display("%0t: result word with nothing expected", $time);
				errors++;
			end else begin
				want = view_q.pop_front();
				if (throttle_width !== want.throttle_width)
					mismatch("throttle_width", want.throttle_width, throttle_width);
				if (steering_width !== want.steering_width)
					mismatch("steering_width", want.steering_width, steering_width);
				if (knob_width !== want.knob_width)
					mismatch("knob_width", want.knob_width, knob_width);
				if (button_width !== want.button_width)
					mismatch("button_width", want.button_width, button_width);
				if (steering_norm !== want.steering_norm)
					mismatch("steering_norm", want.steering_norm, steering_norm);
				if (throttle_level !== want.throttle_level)
					mismatch("throttle_level", want.throttle_level, throttle_level);
				if (brake_level !== want.brake_level)
					mismatch("brake_level", want.brake_level, brake_level);
				if (auto_mode !== want.auto_mode)
					mismatch("auto_mode", want.auto_mode, auto_mode);
				if (forward !== want.forward)
					mismatch("forward", want.forward, forward);
			end
		end
	end

	// watchdog on traffic, not on total run length
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		// tracked state starts from the reset values
		cfg = '{pulse_min: PULSE_MIN_RST, pulse_max: PULSE_MAX_RST,
			press_level: PRESS_LEVEL_RST, lift_level: LIFT_LEVEL_RST,
			forward_level: FORWARD_LEVEL_RST};
		for (int i = 0; i < NUM_CH; i++) begin
			start_q[i] = '0;
			armed_q[i] = 1'b0;
			width_q[i] = WIDTH_RST;
			gen_armed[i] = 1'b0;
			gen_start[i] = '0;
		end
		pressed_q = FLAGS_RST.pressed;
		lifted_q = FLAGS_RST.lifted;
		auto_q = FLAGS_RST.auto_mode;
		fwd_q = FLAGS_RST.forward;
		gen_now = $urandom();

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed edges at the reset settings
		push_edge(CH_THROTTLE, 1'b0, 32'h0000_0000);   // fall with nothing open
		push_edge(CH_THROTTLE, 1'b1, 32'hFFFF_FF00);   // pulse across the timer wrap
		push_edge(CH_THROTTLE, 1'b0, 32'h0000_0400);
		push_edge(CH_THROTTLE, 1'b1, 32'h0000_0000);   // widest possible pulse, full throttle
		push_edge(CH_THROTTLE, 1'b0, 32'hFFFF_FFFF);
		push_edge(CH_THROTTLE, 1'b1, 32'd100);         // runt pulse, full brake
		push_edge(CH_THROTTLE, 1'b0, 32'd103);
		push_edge(CH_STEERING, 1'b1, 32'd10);          // second rise moves the start
		push_edge(CH_STEERING, 1'b1, 32'd1000);
		push_edge(CH_STEERING, 1'b0, 32'd2200);
		push_edge(CH_STEERING, 1'b1, 32'd5000);        // steering hard over
		push_edge(CH_STEERING, 1'b0, 32'd7100);
		push_edge(CH_KNOB, 1'b1, 32'd0);               // knob low, reverse
		push_edge(CH_KNOB, 1'b0, 32'd1100);
		push_edge(CH_KNOB, 1'b1, 32'd3000);            // knob high, forward again
		push_edge(CH_KNOB, 1'b0, 32'd4900);
		push_edge(CH_BUTTON, 1'b1, 32'd0);             // press
		push_edge(CH_BUTTON, 1'b0, 32'd1700);
		push_edge(CH_BUTTON, 1'b1, 32'd10000);         // lift, auto mode on
		push_edge(CH_BUTTON, 1'b0, 32'd11300);
		push_edge(CH_BUTTON, 1'b1, 32'd0);             // saturated button width
		push_edge(CH_BUTTON, 1'b0, 32'h0010_0000);
		push_edge(CH_BUTTON, 1'b1, 32'd5);             // lift right at the level, auto off
		push_edge(CH_BUTTON, 1'b0, 32'd1405);
		push_edge(CH_BUTTON, 1'b1, 32'd9000);          // press right at the level
		push_edge(CH_BUTTON, 1'b0, 32'd10600);
		push_edge(CH_BUTTON, 1'b0, 32'd10700);         // stray fall on the button
		drain();

		// writes past the register list must change nothing
		write_reg(REG_SPARE_LO, 16'($urandom()));
		write_reg(REG_SPARE_HI, 16'($urandom()));
		write_reg(3'($urandom_range(REG_SPARE_HI, REG_SPARE_LO)), 16'($urandom()));
		gen_edges(100);
		drain();

		// wide open limits, always pressed and always lifted, always forward
		set_config(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
		gen_edges(85);
		drain();

		// min above max, press unreachable short of saturation, forward for knob pulses below 0xFFFF
		set_config(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
		gen_edges(85);
		drain();

		// arbitrary settings
		set_config(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
			16'($urandom()));
		gen_edges(85);
		drain();

		// hysteresis levels crossed, both flags can be up together
		set_config(16'($urandom_range(1100, 900)), 16'($urandom_range(2100, 1900)),
			16'($urandom_range(1450, 1250)), 16'($urandom_range(1750, 1550)),
			16'($urandom_range(1600, 1000)));
		gen_edges(85);
		drain();

		// back to stock settings, no idling at all apart from one long receiver
		// hold-off while the sender keeps pushing, so the pipe fills and stalls
		set_config(PULSE_MIN_RST, PULSE_MAX_RST, PRESS_LEVEL_RST, LIFT_LEVEL_RST,
			FORWARD_LEVEL_RST);
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_at = n_in + 30;
		gen_edges(110);
		drain();

		if (view_q.size() != 0) begin
			$display("%0t: %0d decoded views never came out", $time, view_q.size());
			errors += view_q.size();
		end
		$display("edge words %0d, result words %0d, register settings %0d",
			n_in, n_out, n_settings);
		$display("auto mode flips %0d, receiver hold-off %0d cycles, mismatches %0d",
			n_toggle, HOLD_CYCLES, errors);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
